FILE: hw/rtl/szpd_pkg.sv
// ----------------------------------------------------------------------------
// szpd_pkg: shared types and constants of the smoothed z-score peak detector
// Widths, register indexes, sequencer steps and control bundles.
// ----------------------------------------------------------------------------
package szpd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_WINDOW  = 64;
  localparam int PTR_W       = $clog2(MAX_WINDOW);
  localparam int LEN_W       = PTR_W + 1;
  localparam int SUM_W       = SAMPLE_BITS + PTR_W + 1;      // window sum, signed
  localparam int SMAG_W      = SUM_W - 1;                    // |sum|
  localparam int SQ_W        = 2 * SAMPLE_BITS + PTR_W - 1;  // sum of squares
  localparam int FSQ_W       = 2 * SAMPLE_BITS;              // one squared sample
  localparam int D_W         = SUM_W + 1;                    // L*y - S, signed
  localparam int DMAG_W      = D_W - 1;
  localparam int LHS_W       = 2 * DMAG_W - 1;               // d^2
  localparam int VAR_W       = SQ_W + PTR_W;                 // L*Q - S^2
  localparam int THR_W       = 16;
  localparam int T2_W        = 2 * THR_W;
  localparam int INF_W       = 17;
  localparam int FRAC        = 16;
  localparam int SPLIT       = 24;                           // operand split point
  localparam int VHI_W       = VAR_W - SPLIT;
  localparam int QHI_W       = SQ_W - SPLIT;
  localparam int RHS_W       = T2_W + VAR_W + 1;
  localparam int MA_W        = 32;
  localparam int MB_W        = 24;
  localparam int P_W         = MA_W + MB_W;
  localparam int BP_W        = INF_W + SAMPLE_BITS;          // blend product
  localparam int CFG_W       = 17;
  localparam int IDX_W       = 2;

  localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WINDOW);
  localparam logic [LEN_W-1:0] LEN_RST = LEN_W'(32);
  localparam logic [THR_W-1:0] THR_RST = THR_W'(1280);
  localparam logic [INF_W-1:0] INF_RST = '0;
  localparam logic [INF_W-1:0] INF_ONE = INF_W'(65536);

  localparam logic [IDX_W-1:0] REG_WINDOW_LENGTH = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_THRESHOLD     = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_INFLUENCE     = IDX_W'(2);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LY,    // L*|y|
    ST_TT,    // T*T, form d
    ST_SS,    // S*S
    ST_DD,    // d*d
    ST_QLO,   // L*Q low part
    ST_QHI,   // L*Q high part
    ST_VAR,   // finish variance term
    ST_VLO,   // t2*var low part
    ST_VHI,   // t2*var high part
    ST_CMP,   // finish right-hand side
    ST_FLAG,  // compare, start blend product
    ST_MIX,   // blended value
    ST_SQF,   // filt^2
    ST_SQO,   // old^2, add new sample to sums
    ST_UPD    // retire old sample, commit, hand result over
  } szpd_state_t;

  typedef enum logic [3:0] {
    MOP_NONE,
    MOP_LY,
    MOP_TT,
    MOP_SS,
    MOP_DD,
    MOP_QLO,
    MOP_QHI,
    MOP_VLO,
    MOP_VHI,
    MOP_BLD,
    MOP_SQF,
    MOP_SQO
  } szpd_mop_t;

  typedef struct packed {
    logic start;     // input beat offered
    logic warm;      // window not yet full
    logic hit;       // z-score test passed
    logic out_free;  // output register can take a result
  } szpd_sts_t;

  typedef struct packed {
    szpd_state_t step;
    szpd_mop_t   mop;
    logic        in_ready;
  } szpd_ctl_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] y_mag;
    logic [LEN_W-1:0]       len;
    logic [THR_W-1:0]       thr;
    logic [SMAG_W-1:0]      s_mag;
    logic [DMAG_W-1:0]      d_mag;
    logic [SQ_W-1:0]        q;
    logic [T2_W-1:0]        t2;
    logic [VAR_W-1:0]       variance;
    logic [INF_W-1:0]       w;
    logic [SAMPLE_BITS-1:0] dif_mag;
    logic [SAMPLE_BITS-1:0] filt_mag;
    logic [SAMPLE_BITS-1:0] old_mag;
  } szpd_mul_src_t;

endpackage

FILE: hw/rtl/szpd_ram.sv
// ----------------------------------------------------------------------------
// szpd_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module szpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/szpd_mul.sv
// ----------------------------------------------------------------------------
// szpd_mul: shared unsigned multiplier
// Picks two magnitudes by operation code and registers their product.
// ----------------------------------------------------------------------------
module szpd_mul
  import szpd_pkg::*;
(
  input  logic          clk,
  input  szpd_mop_t     mop,
  input  szpd_mul_src_t src,
  output logic [P_W-1:0] prod
);

  logic [MA_W-1:0] a;
  logic [MB_W-1:0] b;
  logic [P_W-1:0]  prod_r;

  always_comb begin
    a = '0;
    b = '0;
    unique case (mop)
      MOP_LY: begin
        a = MA_W'(src.y_mag);
        b = MB_W'(src.len);
      end
      MOP_TT: begin
        a = MA_W'(src.thr);
        b = MB_W'(src.thr);
      end
      MOP_SS: begin
        a = MA_W'(src.s_mag);
        b = MB_W'(src.s_mag);
      end
      MOP_DD: begin
        a = MA_W'(src.d_mag);
        b = MB_W'(src.d_mag);
      end
      MOP_QLO: begin
        a = MA_W'(src.len);
        b = src.q[SPLIT-1:0];
      end
      MOP_QHI: begin
        a = MA_W'(src.len);
        b = MB_W'(src.q[SQ_W-1:SPLIT]);
      end
      MOP_VLO: begin
        a = src.t2;
        b = src.variance[SPLIT-1:0];
      end
      MOP_VHI: begin
        a = src.t2;
        b = MB_W'(src.variance[VAR_W-1:SPLIT]);
      end
      MOP_BLD: begin
        a = MA_W'(src.w);
        b = MB_W'(src.dif_mag);
      end
      MOP_SQF: begin
        a = MA_W'(src.filt_mag);
        b = MB_W'(src.filt_mag);
      end
      MOP_SQO: begin
        a = MA_W'(src.old_mag);
        b = MB_W'(src.old_mag);
      end
      MOP_NONE: begin
        a = '0;
        b = '0;
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
  end

  // product holds on idle steps; later steps still read it
  always_ff @(posedge clk) begin
    if (mop != MOP_NONE) begin
      prod_r <= P_W'(a) * P_W'(b);
    end
  end

  assign prod = prod_r;

endmodule

FILE: hw/rtl/szpd_ctrl.sv
// ----------------------------------------------------------------------------
// szpd_ctrl: step sequencer
// Walks one sample through the multiplier schedule and the window update.
// ----------------------------------------------------------------------------
module szpd_ctrl
  import szpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  szpd_sts_t sts,
  output szpd_ctl_t ctl
);

  szpd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ctl.step     = state_r;
    ctl.mop      = MOP_NONE;
    ctl.in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        ctl.in_ready = 1'b1;
        if (sts.start) begin
          state_nxt = sts.warm ? ST_SQF : ST_LY;
        end
      end
      ST_LY: begin
        ctl.mop   = MOP_LY;
        state_nxt = ST_TT;
      end
      ST_TT: begin
        ctl.mop   = MOP_TT;
        state_nxt = ST_SS;
      end
      ST_SS: begin
        ctl.mop   = MOP_SS;
        state_nxt = ST_DD;
      end
      ST_DD: begin
        ctl.mop   = MOP_DD;
        state_nxt = ST_QLO;
      end
      ST_QLO: begin
        ctl.mop   = MOP_QLO;
        state_nxt = ST_QHI;
      end
      ST_QHI: begin
        ctl.mop   = MOP_QHI;
        state_nxt = ST_VAR;
      end
      ST_VAR: begin
        state_nxt = ST_VLO;
      end
      ST_VLO: begin
        ctl.mop   = MOP_VLO;
        state_nxt = ST_VHI;
      end
      ST_VHI: begin
        ctl.mop   = MOP_VHI;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = ST_FLAG;
      end
      ST_FLAG: begin
        // blend product is issued either way, used only on a hit
        ctl.mop   = MOP_BLD;
        state_nxt = sts.hit ? ST_MIX : ST_SQF;
      end
      ST_MIX: begin
        state_nxt = ST_SQF;
      end
      ST_SQF: begin
        ctl.mop   = MOP_SQF;
        state_nxt = ST_SQO;
      end
      ST_SQO: begin
        ctl.mop   = MOP_SQO;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/smoothed_zscore_peak_detect_unit.sv
// ----------------------------------------------------------------------------
// smoothed_zscore_peak_detect_unit: smoothed z-score peak detector, top level
// Window state, datapath registers and the result register.
// ----------------------------------------------------------------------------
// Each input beat is one signed sample; each yields one result beat with the
// peak flag (+1 above the band, -1 below, 0 inside), a warming bit while the
// window fills, and the value pushed into the window. The test is
// (L*y - S)^2 * 2^16 > T^2 * (L*Q - S^2), exact, with S and Q the running sum
// and sum of squares of the last L window values. All products go through one
// 32x24 multiplier driven by a step sequencer, so the block takes one sample
// at a time: it takes no new sample until the last one is committed, and a
// tested sample runs more steps than one that only fills the window.
// A finished result waits in the output register while the next sample is
// already being worked on. Writing window_length restarts the window.
// ----------------------------------------------------------------------------
module smoothed_zscore_peak_detect_unit
  import szpd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [1:0]       out_peak_signal,
  output logic                    out_warming,
  output logic signed [SAMPLE_BITS-1:0] out_filtered_sample,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  // configuration
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [THR_W-1:0] thr_r, thr_nxt;
  logic [INF_W-1:0] inf_r, inf_nxt;
  // window state
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [LEN_W-1:0] seen_r, seen_nxt;
  logic signed [SUM_W-1:0] s_r, s_nxt;
  logic [SQ_W-1:0]  q_r, q_nxt;
  sample_t          lf_r, lf_nxt;
  // per-sample work registers
  sample_t          y_r, y_nxt;
  logic             warm_r, warm_nxt;
  logic             flag_r, flag_nxt;
  sample_t          filt_r, filt_nxt;
  logic signed [D_W-1:0] d_r, d_nxt;
  logic [T2_W-1:0]  t2_r, t2_nxt;
  logic [VAR_W-1:0] s2_r, s2_nxt;
  logic [LHS_W-1:0] lhs_r, lhs_nxt;
  logic [VAR_W-1:0] var_r, var_nxt;
  logic [RHS_W-1:0] rhs_r, rhs_nxt;
  // result register
  logic             out_valid_r, out_valid_nxt;
  logic signed [1:0] out_sig_r, out_sig_nxt;
  logic             out_warm_r, out_warm_nxt;
  sample_t          out_filt_r, out_filt_nxt;

  szpd_ctl_t     ctl;
  szpd_sts_t     sts;
  szpd_mul_src_t src;
  logic [P_W-1:0] prod;
  sample_t       old_s;

  logic accept;
  logic out_free;
  logic full;
  logic commit;
  logic hit;
  logic [LEN_W-1:0] wptr_inc;
  logic [LEN_W-1:0] cfg_len;
  logic signed [D_W-1:0] ly_s;
  logic signed [SAMPLE_BITS:0] dif_s;
  logic signed [BP_W+1:0] bld_s;
  logic signed [BP_W+1:0] rnd_s;
  logic signed [SAMPLE_BITS+1:0] mix_s;

  assign accept   = in_valid & ctl.in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign full     = !warm_r;
  assign commit   = (ctl.step == ST_UPD) && out_free;
  assign hit      = RHS_W'({lhs_r, FRAC'(0)}) > rhs_r;

  assign sts.start    = in_valid;
  assign sts.warm     = seen_r < len_r;
  assign sts.hit      = hit;
  assign sts.out_free = out_free;

  szpd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  // magnitudes for the shared multiplier
  always_comb begin
    dif_s        = {y_r[SAMPLE_BITS-1], y_r} - {lf_r[SAMPLE_BITS-1], lf_r};
    src.y_mag    = y_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(-y_r) : SAMPLE_BITS'(y_r);
    src.len      = len_r;
    src.thr      = thr_r;
    src.s_mag    = s_r[SUM_W-1] ? SMAG_W'(-s_r) : SMAG_W'(s_r);
    src.d_mag    = d_r[D_W-1] ? DMAG_W'(-d_r) : DMAG_W'(d_r);
    src.q        = q_r;
    src.t2       = t2_r;
    src.variance = var_r;
    src.w        = inf_r;
    src.dif_mag  = dif_s[SAMPLE_BITS] ? SAMPLE_BITS'(-dif_s) : SAMPLE_BITS'(dif_s);
    src.filt_mag = filt_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(-filt_r) : SAMPLE_BITS'(filt_r);
    src.old_mag  = old_s[SAMPLE_BITS-1] ? SAMPLE_BITS'(-old_s) : SAMPLE_BITS'(old_s);
  end

  szpd_mul u_mul (
    .clk  (clk),
    .mop  (ctl.mop),
    .src  (src),
    .prod (prod)
  );

  szpd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (commit),
    .waddr (wptr_r),
    .wdata (filt_r),
    .re    (accept),
    .raddr (wptr_r),
    .rdata (old_s)
  );

  // signed L*y, and the rounded blend lf + (w*(y-lf) + 1/2) >> 16
  always_comb begin
    ly_s  = y_r[SAMPLE_BITS-1] ? -$signed({2'b00, prod[SMAG_W-1:0]})
                               :  $signed({2'b00, prod[SMAG_W-1:0]});
    bld_s = dif_s[SAMPLE_BITS] ? -$signed({2'b00, prod[BP_W-1:0]})
                               :  $signed({2'b00, prod[BP_W-1:0]});
    rnd_s = (bld_s + $signed((BP_W+2)'(1 << (FRAC - 1)))) >>> FRAC;
    mix_s = $signed({{2{lf_r[SAMPLE_BITS-1]}}, lf_r}) + rnd_s[SAMPLE_BITS+1:0];
  end

  always_comb begin
    wptr_inc = LEN_W'(wptr_r) + LEN_W'(1);
    cfg_len  = cfg_wdata[LEN_W-1:0];
    if (cfg_len < LEN_MIN) begin
      cfg_len = LEN_MIN;
    end else if (cfg_len > LEN_MAX) begin
      cfg_len = LEN_MAX;
    end
  end

  always_comb begin
    len_nxt       = len_r;
    thr_nxt       = thr_r;
    inf_nxt       = inf_r;
    wptr_nxt      = wptr_r;
    seen_nxt      = seen_r;
    s_nxt         = s_r;
    q_nxt         = q_r;
    lf_nxt        = lf_r;
    y_nxt         = y_r;
    warm_nxt      = warm_r;
    flag_nxt      = flag_r;
    filt_nxt      = filt_r;
    d_nxt         = d_r;
    t2_nxt        = t2_r;
    s2_nxt        = s2_r;
    lhs_nxt       = lhs_r;
    var_nxt       = var_r;
    rhs_nxt       = rhs_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_sig_nxt   = out_sig_r;
    out_warm_nxt  = out_warm_r;
    out_filt_nxt  = out_filt_r;

    if (accept) begin
      y_nxt    = in_sample;
      filt_nxt = in_sample;
      warm_nxt = seen_r < len_r;
      flag_nxt = 1'b0;
    end

    unique case (ctl.step)
      ST_TT:   d_nxt   = ly_s - D_W'(s_r);
      ST_SS:   t2_nxt  = prod[T2_W-1:0];
      ST_DD:   s2_nxt  = prod[VAR_W-1:0];
      ST_QLO:  lhs_nxt = prod[LHS_W-1:0];
      // partial values wrap; the finished variance is non-negative
      ST_QHI:  var_nxt = prod[VAR_W-1:0] - s2_r;
      ST_VAR:  var_nxt = var_r + {prod[VHI_W-1:0], SPLIT'(0)};
      ST_VHI:  rhs_nxt = RHS_W'(prod);
      ST_CMP:  rhs_nxt = rhs_r + RHS_W'({prod[T2_W+VHI_W-1:0], SPLIT'(0)});
      ST_FLAG: flag_nxt = hit;
      ST_MIX:  filt_nxt = mix_s[SAMPLE_BITS-1:0];
      ST_SQO: begin
        q_nxt = q_r + SQ_W'(prod[FSQ_W-1:0]);
        s_nxt = s_r + SUM_W'(filt_r);
      end
      ST_UPD: begin
        if (out_free) begin
          if (full) begin
            q_nxt = q_r - SQ_W'(prod[FSQ_W-1:0]);
            s_nxt = s_r - SUM_W'(old_s);
          end else begin
            seen_nxt = seen_r + LEN_W'(1);
          end
          wptr_nxt      = (wptr_inc >= len_r) ? '0 : wptr_inc[PTR_W-1:0];
          lf_nxt        = filt_r;
          out_valid_nxt = 1'b1;
          out_warm_nxt  = warm_r;
          out_filt_nxt  = filt_r;
          if (!flag_r) begin
            out_sig_nxt = 2'sd0;
          end else if (!d_r[D_W-1] && (d_r != '0)) begin
            out_sig_nxt = 2'sd1;
          end else begin
            out_sig_nxt = -2'sd1;
          end
        end
      end
      ST_IDLE, ST_LY, ST_VLO, ST_SQF: begin
      end
      default: begin
      end
    endcase

    if (cfg_we) begin
      priority case (cfg_index)
        REG_WINDOW_LENGTH: begin
          len_nxt  = cfg_len;
          wptr_nxt = '0;
          seen_nxt = '0;
          s_nxt    = '0;
          q_nxt    = '0;
        end
        REG_THRESHOLD: thr_nxt = cfg_wdata[THR_W-1:0];
        REG_INFLUENCE: inf_nxt = (cfg_wdata > CFG_W'(INF_ONE)) ? INF_ONE
                                                                : cfg_wdata[INF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LEN_RST;
      thr_r       <= THR_RST;
      inf_r       <= INF_RST;
      wptr_r      <= '0;
      seen_r      <= '0;
      s_r         <= '0;
      q_r         <= '0;
      lf_r        <= '0;
      warm_r      <= 1'b0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      thr_r       <= thr_nxt;
      inf_r       <= inf_nxt;
      wptr_r      <= wptr_nxt;
      seen_r      <= seen_nxt;
      s_r         <= s_nxt;
      q_r         <= q_nxt;
      lf_r        <= lf_nxt;
      warm_r      <= warm_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    y_r        <= y_nxt;
    filt_r     <= filt_nxt;
    d_r        <= d_nxt;
    t2_r       <= t2_nxt;
    s2_r       <= s2_nxt;
    lhs_r      <= lhs_nxt;
    var_r      <= var_nxt;
    rhs_r      <= rhs_nxt;
    out_sig_r  <= out_sig_nxt;
    out_warm_r <= out_warm_nxt;
    out_filt_r <= out_filt_nxt;
  end

  assign in_ready            = ctl.in_ready;
  assign out_valid           = out_valid_r;
  assign out_peak_signal     = out_sig_r;
  assign out_warming         = out_warm_r;
  assign out_filtered_sample = out_filt_r;

`ifndef SYNTHESIS
  a_seen_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= len_r)
    else $error("sample count beyond window length");

  a_ptr_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    wptr_r < len_r)
    else $error("write pointer outside window");

  a_var_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.step == ST_VLO) |-> !var_r[VAR_W-1])
    else $error("variance term out of range");

  a_no_flag_warm: assert property (@(posedge clk) disable iff (!rst_n)
    flag_r |-> !warm_r)
    else $error("sample flagged while window warming");
`endif

endmodule
